### src/sbf_pkg.sv
// Shared field widths, the reset side, the count ceiling and the result type for the square block finder.
package sbf_pkg;

    localparam int SIDE_W   = 7;
    localparam int CENTRE_W = 6;
    localparam int COUNT_W  = 12;

    localparam logic [SIDE_W-1:0]  SIDE_RESET = 7'd50;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 12'hFFF;

    typedef struct packed {
        logic                found;
        logic [CENTRE_W-1:0] centre_row;
        logic [CENTRE_W-1:0] centre_col;
        logic [COUNT_W-1:0]  window_count;
    } t_result;

endpackage

### src/square_block_finder_core.sv
// Streaming detector of fully occupied square windows in a raster occupancy grid.
// The block takes one grid cell per clock in raster order (rows top to bottom,
// columns left to right) and sustains one request per cycle: every cell is
// finished in the cycle it is accepted, by one column counter update and one
// run counter update between the state registers. The per-column counts live in
// a GRID_MAX-entry memory whose read for the next cell is issued ahead of it
// (the column of the following cell is always known), with a bypass for a grid
// one column wide; a valid bit per column clears the counts at once on reset,
// on a register write and at the end of every frame, so there is no clearing
// pass. On the last cell of a frame one result is loaded into the output
// register: found, the centre of the first window in raster order of its
// top-left corner, and the saturating window count. Input is stalled only when
// a finished result still waits downstream and the next cell would end a frame.
// Writing grid_side restarts the frame; write it only while the block is idle.
// A side above GRID_MAX acts as GRID_MAX and a side of zero acts as one.
module square_block_finder_core #(
    parameter int GRID_MAX = 64,
    parameter int WINDOW   = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // cell channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_occupied,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [sbf_pkg::CENTRE_W-1:0]  o_centre_row,
    output logic [sbf_pkg::CENTRE_W-1:0]  o_centre_col,
    output logic [sbf_pkg::COUNT_W-1:0]   o_window_count,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sbf_pkg::SIDE_W-1:0]    i_cfg_grid_side
);
    import sbf_pkg::*;

    localparam int CW = $clog2(GRID_MAX);        // column / row index
    localparam int SW = CW + 1;                  // side, holds GRID_MAX
    localparam int RW = $clog2(WINDOW + 1);      // saturating run counters
    localparam int MW = (SW > SIDE_W) ? SW : SIDE_W;
    localparam int BACK = (WINDOW - 1) - (WINDOW - 1) / 2;
    localparam int RESET_SIDE = (50 > GRID_MAX) ? GRID_MAX : 50;

    localparam logic [RW-1:0] WIN = RW'(WINDOW);

    // frame state
    logic [SW-1:0]       r_side;
    logic [CW-1:0]       r_col,   n_col;
    logic [CW-1:0]       r_row,   n_row;
    logic [RW-1:0]       r_wide,  n_wide;
    logic                r_have,  n_have;
    logic [CW-1:0]       r_first_row, n_first_row;
    logic [CW-1:0]       r_first_col, n_first_col;
    logic [COUNT_W-1:0]  r_total, n_total;
    logic                n_clear;

    // column count memory, its valid bits and the prefetched read
    logic [RW-1:0]       mem [GRID_MAX];
    logic [GRID_MAX-1:0] r_vld;
    logic [RW-1:0]       r_rd;

    // result register
    logic                r_ovalid;
    t_result             r_res, n_res;

    logic                accept;
    logic                cfg_wr;
    logic                last_col;
    logic                last_row;
    logic                frame_end;
    logic                hit;
    logic [RW-1:0]       cur_run;
    logic [RW-1:0]       col_new;
    logic [RW-1:0]       wide_new;
    logic [MW-1:0]       cfg_ext;
    logic [SW-1:0]       cfg_side;

    // clamp the written side into 1..GRID_MAX
    always_comb begin
        cfg_ext = MW'(i_cfg_grid_side);
        if (cfg_ext > MW'(GRID_MAX)) begin
            cfg_side = SW'(GRID_MAX);
        end else if (cfg_ext == '0) begin
            cfg_side = SW'(1);
        end else begin
            cfg_side = SW'(cfg_ext);
        end
    end

    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    assign last_col  = (SW'(r_col) + SW'(1)) >= r_side;
    assign last_row  = (SW'(r_row) + SW'(1)) >= r_side;
    assign frame_end = last_col && last_row;

    // hold the cell only when this one would overwrite a waiting result
    assign o_stall = r_ovalid && i_stall && frame_end;
    assign accept  = i_valid && !o_stall;

    // per-cell update of the column count and the run of full columns
    always_comb begin
        cur_run = r_vld[r_col] ? r_rd : '0;
        if (!i_occupied) begin
            col_new = '0;
        end else if (cur_run < WIN) begin
            col_new = cur_run + RW'(1);
        end else begin
            col_new = cur_run;
        end

        if (col_new < WIN) begin
            wide_new = '0;
        end else if (r_wide < WIN) begin
            wide_new = r_wide + RW'(1);
        end else begin
            wide_new = r_wide;
        end

        hit = (wide_new >= WIN)
            && (32'(r_row) >= WINDOW - 1)
            && (32'(r_col) >= WINDOW - 1);
    end

    // next frame state and the result built on a frame's last cell
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_wide      = r_wide;
        n_have      = r_have;
        n_first_row = r_first_row;
        n_first_col = r_first_col;
        n_total     = r_total;
        n_clear     = 1'b0;
        n_res       = r_res;

        if (accept) begin
            n_wide = wide_new;
            if (hit) begin
                if (!r_have) begin
                    n_have      = 1'b1;
                    n_first_row = r_row - CW'(BACK);
                    n_first_col = r_col - CW'(BACK);
                end
                if (r_total != COUNT_MAX) begin
                    n_total = r_total + COUNT_W'(1);
                end
            end

            if (last_col) begin
                n_col  = '0;
                n_wide = '0;
                if (last_row) begin
                    n_res.found        = n_have;
                    n_res.centre_row   = n_have ? CENTRE_W'(n_first_row) : '0;
                    n_res.centre_col   = n_have ? CENTRE_W'(n_first_col) : '0;
                    n_res.window_count = n_total;
                    n_clear            = 1'b1;
                end else begin
                    n_row = r_row + CW'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end

        // drop the frame on its end or on a side write
        if (n_clear || cfg_wr) begin
            n_col       = '0;
            n_row       = '0;
            n_wide      = '0;
            n_have      = 1'b0;
            n_first_row = '0;
            n_first_col = '0;
            n_total     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= SW'(RESET_SIDE);
            r_col       <= '0;
            r_row       <= '0;
            r_wide      <= '0;
            r_have      <= 1'b0;
            r_first_row <= '0;
            r_first_col <= '0;
            r_total     <= '0;
            r_vld       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_side <= cfg_side;
            end
            r_col       <= n_col;
            r_row       <= n_row;
            r_wide      <= n_wide;
            r_have      <= n_have;
            r_first_row <= n_first_row;
            r_first_col <= n_first_col;
            r_total     <= n_total;

            if (n_clear || cfg_wr) begin
                r_vld <= '0;
            end else if (accept) begin
                r_vld[r_col] <= 1'b1;
            end

            if (accept && frame_end) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // write the current column, prefetch the next cell's column;
    // bypass when both are the same column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[r_col] <= col_new;
        end
        if (accept && (n_col == r_col)) begin
            r_rd <= col_new;
        end else begin
            r_rd <= mem[n_col];
        end
    end

    // result payload, advanced only when the last cell of a frame is taken
    always_ff @(posedge i_clk) begin
        if (accept && frame_end) begin
            r_res <= n_res;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_found        = r_res.found;
    assign o_centre_row   = r_res.centre_row;
    assign o_centre_col   = r_res.centre_col;
    assign o_window_count = r_res.window_count;

    // a result appears only after the last cell of a frame was taken
    a_result_from_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(accept && frame_end))
        else $error("result raised without a frame end");

    // the cell position stays inside the grid in use
    a_position_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_col) < r_side) && (SW'(r_row) < r_side))
        else $error("cell position outside the grid");

    // an empty result carries a zero centre
    a_empty_centre_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> ((o_centre_row == '0) && (o_centre_col == '0)))
        else $error("centre set on a result without a window");

endmodule
